FILE: design/gbs_pkg.sv
// Shared constants and helper functions for the Gaussian bump surface evaluator.
`timescale 1ns / 1ps
`default_nettype none
package gbs_pkg;

  // Fixed point format of the ports.
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned Q30_SHIFT = 30 - FRAC_BITS;

  // Exponential evaluation.
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam int unsigned EXP_TERMS = 12;
  localparam int unsigned EXP_N_MAX = 17;
  localparam int unsigned T_BITS    = 20;
  localparam logic [T_BITS-1:0] EXP_CUTOFF = T_BITS'(12 << FRAC_BITS);

  // Configuration register indexes.
  localparam logic [1:0] REG_AMPLITUDE  = 2'd0;
  localparam logic [1:0] REG_WIDTH_X_SQ = 2'd1;
  localparam logic [1:0] REG_WIDTH_Y_SQ = 2'd2;

  // n times ln(2) in Q30.
  function automatic logic [34:0] ln2_mult(input logic [4:0] n);
    return 35'(n) * 35'(LN2_Q30);
  endfunction

  // floor(2^32 / k) for the series divisors.
  function automatic logic [32:0] recip(input logic [3:0] k);
    logic [32:0] m;
    unique case (k)
      4'd1:    m = 33'd4294967296;
      4'd2:    m = 33'd2147483648;
      4'd3:    m = 33'd1431655765;
      4'd4:    m = 33'd1073741824;
      4'd5:    m = 33'd858993459;
      4'd6:    m = 33'd715827882;
      4'd7:    m = 33'd613566756;
      4'd8:    m = 33'd536870912;
      4'd9:    m = 33'd477218588;
      4'd10:   m = 33'd429496729;
      4'd11:   m = 33'd390451572;
      4'd12:   m = 33'd357913941;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

FILE: design/gaussian_bump_surface_eval_top.sv
// Top level of the Gaussian bump surface evaluator: datapath stages and configuration.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         in_valid_i / in_stall_o    pos_x_i, pos_y_i, pos_z_i
//   result    out        out_valid_o / out_stall_i  grad_*_o, norm_*_o, surface_value_o
//   config    in         cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// The block takes one request per cycle while the output buffer is not full;
// the pipeline depth is set by the three chains of pipelined dividers, the
// twelve-term exponential series and the 32-stage square root.
// Reset clears all valid bits and loads amplitude 1.0 and both squared widths 1.0.
// The whole pipeline advances together; it holds only when the two-entry output
// buffer is full, so a waiting result never blocks new requests by itself.
`timescale 1ns / 1ps
`default_nettype none
module gaussian_bump_surface_eval_top import gbs_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      grad_x_o,
  output logic signed [31:0]      grad_y_o,
  output logic signed [17:0]      grad_z_o,
  output logic signed [17:0]      norm_x_o,
  output logic signed [17:0]      norm_y_o,
  output logic signed [16:0]      norm_z_o,
  output logic signed [31:0]      surface_value_o
);

  localparam int unsigned OUT_W = 32 + 32 + 18 + 18 + 17 + 32;

  // Global advance for every stage.
  logic en;
  assign in_stall_o = !en;

  // Configuration registers; a zero divisor behaves as one.
  logic [31:0] amp_q;
  logic [30:0] wx_q, wy_q;
  logic [30:0] a_eff, b_eff;
  logic [31:0] amp_mag;
  logic        amp_neg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q <= 32'(1 << FRAC_BITS);
      wx_q  <= 31'(1 << FRAC_BITS);
      wy_q  <= 31'(1 << FRAC_BITS);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_AMPLITUDE:  amp_q <= cfg_wdata_i;
        REG_WIDTH_X_SQ: wx_q  <= cfg_wdata_i[30:0];
        REG_WIDTH_Y_SQ: wy_q  <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  assign a_eff   = (wx_q == '0) ? 31'd1 : wx_q;
  assign b_eff   = (wy_q == '0) ? 31'd1 : wy_q;
  assign amp_neg = amp_q[31];
  assign amp_mag = amp_neg ? 32'(-amp_q) : amp_q;

  // Stage 0 captures the request, stage 1 squares the coordinates, stage 2
  // adds the rounding half divisor and checks whether the quotient overflows.
  logic        v0_q, v1_q, v2_q;
  logic [31:0] x0_q, y0_q, z0_q, x1_q, y1_q, z1_q, x2_q, y2_q, z2_q;
  logic [63:0] sqx_q, sqy_q;
  logic [50:0] ntx_q, nty_q;
  logic        otx_q, oty_q;
  logic [31:0] mx0, my0;
  logic [62:0] ntx_d, nty_d;
  logic        otx_d, oty_d;

  assign mx0   = x0_q[31] ? 32'(-x0_q) : x0_q;
  assign my0   = y0_q[31] ? 32'(-y0_q) : y0_q;
  assign ntx_d = 63'(sqx_q) + 63'(a_eff >> 1);
  assign nty_d = 63'(sqy_q) + 63'(b_eff >> 1);
  assign otx_d = ntx_d >= (63'(a_eff) << T_BITS);
  assign oty_d = nty_d >= (63'(b_eff) << T_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q  <= pos_x_i;
      y0_q  <= pos_y_i;
      z0_q  <= pos_z_i;
      sqx_q <= 64'(mx0) * 64'(mx0);
      sqy_q <= 64'(my0) * 64'(my0);
      x1_q  <= x0_q;
      y1_q  <= y0_q;
      z1_q  <= z0_q;
      ntx_q <= otx_d ? '0 : 51'(ntx_d);
      nty_q <= oty_d ? '0 : 51'(nty_d);
      otx_q <= otx_d;
      oty_q <= oty_d;
      x2_q  <= x1_q;
      y2_q  <= y1_q;
      z2_q  <= z1_q;
    end
  end

  // The exponent t = round(x^2/a) + round(y^2/b), quotients limited to 20 bits.
  logic        vtx, vty;
  logic [19:0] qtx, qty;
  logic [96:0] stx;
  logic        sty;

  gbs_div #(.DEN_W(31), .Q_W(T_BITS), .SIDE_W(97)) u_div_tx (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v2_q), .num_i(ntx_q), .den_i(a_eff),
    .side_i({x2_q, y2_q, z2_q, otx_q}), .vld_o(vtx), .quo_o(qtx), .side_o(stx)
  );

  gbs_div #(.DEN_W(31), .Q_W(T_BITS), .SIDE_W(1)) u_div_ty (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v2_q), .num_i(nty_q), .den_i(b_eff),
    .side_i(oty_q), .vld_o(vty), .quo_o(qty), .side_o(sty)
  );

  // Sum the two terms and flag the deep exponent, where e is zero.
  logic        v3_q;
  logic [19:0] t3_q;
  logic [96:0] s3_q;
  logic [20:0] tsum;
  logic        cut;

  assign tsum = 21'(qtx) + 21'(qty);
  assign cut  = stx[0] || sty || (tsum >= 21'(EXP_CUTOFF));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= vtx && vty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t3_q <= cut ? '0 : tsum[19:0];
      s3_q <= {stx[96:1], cut};
    end
  end

  logic        vex;
  logic [16:0] ex;
  logic [96:0] sex;

  gbs_exp #(.SIDE_W(97)) u_exp (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v3_q), .t_i(t3_q), .side_i(s3_q),
    .vld_o(vex), .e_o(ex), .side_o(sex)
  );

  // Stage 4 scales e by |A|, stage 5 rounds it and forms A*e - z,
  // stage 6 forms 2*|Ae|*|x|, stage 7 prepares the gradient division.
  logic        v4_q, v5_q, v6_q, v7_q;
  logic [48:0] ap4_q;
  logic [31:0] x4_q, y4_q, z4_q, x5_q, y5_q;
  logic [31:0] ae5_q;
  logic [31:0] sf5_q, sf6_q, sf7_q;
  logic [63:0] mgx6_q, mgy6_q;
  logic        ngx6_q, ngy6_q, ngx7_q, ngy7_q;
  logic [61:0] ngnx7_q, ngny7_q;
  logic        ogx7_q, ogy7_q;
  logic [16:0] e_eff;
  logic [31:0] ae_mag;
  logic signed [33:0] ae_s, z_s, diff;
  logic [31:0] surf_d;
  logic [31:0] mx5, my5;
  logic [63:0] gnx_d, gny_d;
  logic        ogx_d, ogy_d;

  assign e_eff  = sex[0] ? '0 : ex;
  assign ae_mag = 32'((ap4_q + 49'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
  assign ae_s   = amp_neg ? -$signed({2'b00, ae_mag}) : $signed({2'b00, ae_mag});
  assign z_s    = $signed({{2{z4_q[31]}}, z4_q});
  assign diff   = ae_s - z_s;

  always_comb begin
    if (diff > 34'sd2147483647) begin
      surf_d = 32'h7FFF_FFFF;
    end else if (diff < -34'sd2147483648) begin
      surf_d = 32'h8000_0000;
    end else begin
      surf_d = diff[31:0];
    end
  end

  assign mx5   = x5_q[31] ? 32'(-x5_q) : x5_q;
  assign my5   = y5_q[31] ? 32'(-y5_q) : y5_q;
  assign gnx_d = mgx6_q + 64'(a_eff >> 1);
  assign gny_d = mgy6_q + 64'(b_eff >> 1);
  assign ogx_d = gnx_d >= (64'(a_eff) << 31);
  assign ogy_d = gny_d >= (64'(b_eff) << 31);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (en) begin
      v4_q <= vex;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ap4_q   <= 49'(amp_mag) * 49'(e_eff);
      x4_q    <= sex[96:65];
      y4_q    <= sex[64:33];
      z4_q    <= sex[32:1];
      ae5_q   <= ae_mag;
      sf5_q   <= surf_d;
      x5_q    <= x4_q;
      y5_q    <= y4_q;
      mgx6_q  <= (64'(ae5_q) * 64'(mx5)) << 1;
      mgy6_q  <= (64'(ae5_q) * 64'(my5)) << 1;
      ngx6_q  <= amp_neg == x5_q[31];
      ngy6_q  <= amp_neg == y5_q[31];
      sf6_q   <= sf5_q;
      ngnx7_q <= ogx_d ? '0 : 62'(gnx_d);
      ngny7_q <= ogy_d ? '0 : 62'(gny_d);
      ogx7_q  <= ogx_d;
      ogy7_q  <= ogy_d;
      ngx7_q  <= ngx6_q;
      ngy7_q  <= ngy6_q;
      sf7_q   <= sf6_q;
    end
  end

  // Gradient magnitudes, 31 quotient bits; overflow saturates.
  logic        vgx, vgy;
  logic [30:0] qgx, qgy;
  logic [33:0] sgx;
  logic [1:0]  sgy;

  gbs_div #(.DEN_W(31), .Q_W(31), .SIDE_W(34)) u_div_gx (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v7_q), .num_i(ngnx7_q), .den_i(a_eff),
    .side_i({sf7_q, ngx7_q, ogx7_q}), .vld_o(vgx), .quo_o(qgx), .side_o(sgx)
  );

  gbs_div #(.DEN_W(31), .Q_W(31), .SIDE_W(2)) u_div_gy (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v7_q), .num_i(ngny7_q), .den_i(b_eff),
    .side_i({ogy7_q, ngy7_q}), .vld_o(vgy), .quo_o(qgy), .side_o(sgy)
  );

  // Stage 8 saturates the gradient, stage 9 squares it, stage 10 sums the
  // squares with 1.0^2 for the length.
  logic        v8_q, v9_q, v10_q;
  logic [31:0] gx8_q, gy8_q, gxa8_q, gya8_q, sf8_q;
  logic [31:0] gx9_q, gy9_q, gxa9_q, gya9_q, sf9_q;
  logic [63:0] sqgx9_q, sqgy9_q, rad10_q;
  logic [159:0] s10_q;
  logic        ngx8, ogx8, ngy8, ogy8;
  logic [31:0] gxm8, gym8, gxa_d, gya_d, gx_d, gy_d;

  assign ngx8  = sgx[1];
  assign ogx8  = sgx[0];
  assign ngy8  = sgy[0];
  assign ogy8  = sgy[1];
  assign gxm8  = ogx8 ? 32'h8000_0000 : {1'b0, qgx};
  assign gym8  = ogy8 ? 32'h8000_0000 : {1'b0, qgy};
  assign gxa_d = (!ngx8 && ogx8) ? 32'h7FFF_FFFF : gxm8;
  assign gya_d = (!ngy8 && ogy8) ? 32'h7FFF_FFFF : gym8;
  assign gx_d  = ngx8 ? 32'(-gxa_d) : gxa_d;
  assign gy_d  = ngy8 ? 32'(-gya_d) : gya_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
    end else if (en) begin
      v8_q  <= vgx && vgy;
      v9_q  <= v8_q;
      v10_q <= v9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gx8_q   <= gx_d;
      gy8_q   <= gy_d;
      gxa8_q  <= gxa_d;
      gya8_q  <= gya_d;
      sf8_q   <= sgx[33:2];
      sqgx9_q <= 64'(gxa8_q) * 64'(gxa8_q);
      sqgy9_q <= 64'(gya8_q) * 64'(gya8_q);
      gx9_q   <= gx8_q;
      gy9_q   <= gy8_q;
      gxa9_q  <= gxa8_q;
      gya9_q  <= gya8_q;
      sf9_q   <= sf8_q;
      rad10_q <= sqgx9_q + sqgy9_q + (64'd1 << (2 * FRAC_BITS));
      s10_q   <= {gx9_q, gy9_q, gxa9_q, gya9_q, sf9_q};
    end
  end

  logic         vsq;
  logic [31:0]  len;
  logic [159:0] ssq;

  gbs_isqrt #(.SIDE_W(160)) u_isqrt (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v10_q), .rad_i(rad10_q), .side_i(s10_q),
    .vld_o(vsq), .root_o(len), .side_o(ssq)
  );

  // Stage 11 forms the rounded numerators of the three normal components.
  logic        v11_q;
  logic [48:0] nnx11_q, nny11_q, nnz11_q;
  logic [31:0] len11_q, gx11_q, gy11_q, sf11_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v11_q <= 1'b0;
    end else if (en) begin
      v11_q <= vsq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nnx11_q <= (49'(ssq[95:64]) << FRAC_BITS) + 49'(len >> 1);
      nny11_q <= (49'(ssq[63:32]) << FRAC_BITS) + 49'(len >> 1);
      nnz11_q <= (49'd1 << (2 * FRAC_BITS)) + 49'(len >> 1);
      len11_q <= len;
      gx11_q  <= ssq[159:128];
      gy11_q  <= ssq[127:96];
      sf11_q  <= ssq[31:0];
    end
  end

  logic        vnx, vny, vnz;
  logic [16:0] qnx, qny, qnz;
  logic [31:0] snx, sny, snz;

  gbs_div #(.DEN_W(32), .Q_W(17), .SIDE_W(32)) u_div_nx (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v11_q), .num_i(nnx11_q), .den_i(len11_q),
    .side_i(gx11_q), .vld_o(vnx), .quo_o(qnx), .side_o(snx)
  );

  gbs_div #(.DEN_W(32), .Q_W(17), .SIDE_W(32)) u_div_ny (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v11_q), .num_i(nny11_q), .den_i(len11_q),
    .side_i(gy11_q), .vld_o(vny), .quo_o(qny), .side_o(sny)
  );

  gbs_div #(.DEN_W(32), .Q_W(17), .SIDE_W(32)) u_div_nz (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v11_q), .num_i(nnz11_q), .den_i(len11_q),
    .side_i(sf11_q), .vld_o(vnz), .quo_o(qnz), .side_o(snz)
  );

  // Apply the gradient signs and hand the result to the output buffer.
  logic [17:0]      nx_d, ny_d;
  logic [16:0]      nz_d;
  logic [OUT_W-1:0] res_d, res_o;
  logic             push;

  assign nx_d  = snx[31] ? 18'(-{1'b0, qnx}) : {1'b0, qnx};
  assign ny_d  = sny[31] ? 18'(-{1'b0, qny}) : {1'b0, qny};
  assign nz_d  = 17'(-qnz);
  assign res_d = {snx, sny, nx_d, ny_d, nz_d, snz};
  assign push  = vnx && vny && vnz && en;

  gbs_obuf #(.W(OUT_W)) u_obuf (
    .clk_i, .rst_ni, .push_i(push), .data_i(res_d), .ready_o(en),
    .out_valid_o, .out_stall_i, .data_o(res_o)
  );

  assign grad_x_o        = res_o[148:117];
  assign grad_y_o        = res_o[116:85];
  assign norm_x_o        = res_o[84:67];
  assign norm_y_o        = res_o[66:49];
  assign norm_z_o        = res_o[48:32];
  assign surface_value_o = res_o[31:0];
  assign grad_z_o        = -18'sd65536;

endmodule
`default_nettype wire

FILE: design/gbs_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module gbs_div #(
  parameter int unsigned DEN_W  = 31,
  parameter int unsigned Q_W    = 20,
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   vld_i,
  input  wire logic [DEN_W+Q_W-1:0]   num_i,
  input  wire logic [DEN_W-1:0]       den_i,
  input  wire logic [SIDE_W-1:0]      side_i,
  output logic                        vld_o,
  output logic [Q_W-1:0]              quo_o,
  output logic [SIDE_W-1:0]           side_o
);

  localparam int unsigned RW = DEN_W + Q_W;

  logic              vld_q  [Q_W];
  logic [RW-1:0]     rem_q  [Q_W];
  logic [Q_W-1:0]    quo_q  [Q_W];
  logic [DEN_W-1:0]  den_q  [Q_W];
  logic [SIDE_W-1:0] side_q [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_step
    localparam int unsigned B = Q_W - 1 - j;
    logic              vld_s;
    logic [RW-1:0]     rem_s;
    logic [Q_W-1:0]    quo_s;
    logic [DEN_W-1:0]  den_s;
    logic [SIDE_W-1:0] side_s;
    logic [RW-1:0]     trial;
    logic              ge;

    if (j == 0) begin : g_first
      assign vld_s  = vld_i;
      assign rem_s  = num_i;
      assign quo_s  = '0;
      assign den_s  = den_i;
      assign side_s = side_i;
    end else begin : g_next
      assign vld_s  = vld_q[j-1];
      assign rem_s  = rem_q[j-1];
      assign quo_s  = quo_q[j-1];
      assign den_s  = den_q[j-1];
      assign side_s = side_q[j-1];
    end

    assign trial = RW'(den_s) << B;
    assign ge    = rem_s >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? rem_s - trial : rem_s;
        quo_q[j]  <= ge ? (quo_s | (Q_W'(1) << B)) : quo_s;
        den_q[j]  <= den_s;
        side_q[j] <= side_s;
      end
    end
  end

  assign vld_o  = vld_q[Q_W-1];
  assign quo_o  = quo_q[Q_W-1];
  assign side_o = side_q[Q_W-1];

endmodule
`default_nettype wire

FILE: design/gbs_isqrt.sv
// Pipelined 64-bit integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module gbs_isqrt #(
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              vld_i,
  input  wire logic [63:0]       rad_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   vld_o,
  output logic [31:0]            root_o,
  output logic [SIDE_W-1:0]      side_o
);

  localparam int unsigned STEPS = 32;

  logic              vld_q  [STEPS];
  logic [63:0]       rem_q  [STEPS];
  logic [63:0]       res_q  [STEPS];
  logic [SIDE_W-1:0] side_q [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic              vld_s;
    logic [63:0]       rem_s;
    logic [63:0]       res_s;
    logic [SIDE_W-1:0] side_s;
    logic [63:0]       trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign vld_s  = vld_i;
      assign rem_s  = rad_i;
      assign res_s  = '0;
      assign side_s = side_i;
    end else begin : g_next
      assign vld_s  = vld_q[i-1];
      assign rem_s  = rem_q[i-1];
      assign res_s  = res_q[i-1];
      assign side_s = side_q[i-1];
    end

    assign trial = res_s + BIT;
    assign ge    = rem_s >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? rem_s - trial : rem_s;
        res_q[i]  <= ge ? (res_s >> 1) + BIT : res_s >> 1;
        side_q[i] <= side_s;
      end
    end
  end

  assign vld_o  = vld_q[STEPS-1];
  assign root_o = res_q[STEPS-1][31:0];
  assign side_o = side_q[STEPS-1];

endmodule
`default_nettype wire

FILE: design/gbs_exp.sv
// Pipelined exp(-t): range reduction by ln 2, a twelve-term series and a final shift.
`timescale 1ns / 1ps
`default_nettype none
module gbs_exp import gbs_pkg::*; #(
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              vld_i,
  input  wire logic [T_BITS-1:0] t_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   vld_o,
  output logic [16:0]            e_o,
  output logic [SIDE_W-1:0]      side_o
);

  // Context word: {side, n, r, s}.
  localparam int unsigned S_LSB  = 0;
  localparam int unsigned R_LSB  = 33;
  localparam int unsigned N_LSB  = 63;
  localparam int unsigned SD_LSB = 68;
  localparam int unsigned CW     = SD_LSB + SIDE_W;
  localparam int unsigned T30_W  = T_BITS + Q30_SHIFT;

  // Range reduction stages.
  logic              v0_q, v1_q;
  logic [T30_W-1:0]  t30_q;
  logic [4:0]        n0_q;
  logic [SIDE_W-1:0] sd0_q;
  logic [CW-1:0]     ctx1_q;
  logic [T30_W-1:0]  t30_d;
  logic [4:0]        n_d;
  logic [29:0]       r_d;

  assign t30_d = {t_i, {Q30_SHIFT{1'b0}}};

  always_comb begin
    n_d = '0;
    for (int k = 1; k <= EXP_N_MAX; k++) begin
      if (35'(t30_d) >= ln2_mult(5'(k))) begin
        n_d = 5'(k);
      end
    end
  end

  assign r_d = 30'(35'(t30_q) - ln2_mult(n0_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= vld_i;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t30_q  <= t30_d;
      n0_q   <= n_d;
      sd0_q  <= side_i;
      ctx1_q <= {sd0_q, n0_q, r_d, 33'd1 << 30};
    end
  end

  // Series terms, three stages each: product, reciprocal multiply, correction.
  logic          va_q [EXP_TERMS];
  logic          vb_q [EXP_TERMS];
  logic          vc_q [EXP_TERMS];
  logic [29:0]   pa_q [EXP_TERMS];
  logic [29:0]   pb_q [EXP_TERMS];
  logic [29:0]   qb_q [EXP_TERMS];
  logic [30:0]   tc_q [EXP_TERMS];
  logic [CW-1:0] ca_q [EXP_TERMS];
  logic [CW-1:0] cb_q [EXP_TERMS];
  logic [CW-1:0] cc_q [EXP_TERMS];

  for (genvar j = 0; j < EXP_TERMS; j++) begin : g_term
    localparam logic [3:0] K = 4'(j + 1);
    localparam bit         SUBTRACT = ((j + 1) % 2) == 1;
    logic          v_s;
    logic [30:0]   term_s;
    logic [CW-1:0] ctx_s;
    logic [60:0]   prod;
    logic [62:0]   scaled;
    logic [33:0]   left;
    logic [29:0]   q;
    logic [32:0]   s_old;
    logic [32:0]   s_new;

    if (j == 0) begin : g_first
      assign v_s    = v1_q;
      assign term_s = 31'd1 << 30;
      assign ctx_s  = ctx1_q;
    end else begin : g_next
      assign v_s    = vc_q[j-1];
      assign term_s = tc_q[j-1];
      assign ctx_s  = cc_q[j-1];
    end

    assign prod   = 61'(term_s) * 61'(ctx_s[R_LSB +: 30]);
    assign scaled = 63'(pa_q[j]) * 63'(recip(K));
    assign left   = 34'(pb_q[j]) - 34'(qb_q[j]) * 34'(K);
    assign q      = (left >= 34'(K)) ? qb_q[j] + 30'd1 : qb_q[j];
    assign s_old  = cb_q[j][S_LSB +: 33];
    assign s_new  = SUBTRACT ? s_old - 33'(q) : s_old + 33'(q);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        va_q[j] <= 1'b0;
        vb_q[j] <= 1'b0;
        vc_q[j] <= 1'b0;
      end else if (en_i) begin
        va_q[j] <= v_s;
        vb_q[j] <= va_q[j];
        vc_q[j] <= vb_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pa_q[j] <= 30'(prod >> 30);
        ca_q[j] <= ctx_s;
        pb_q[j] <= pa_q[j];
        qb_q[j] <= 30'(scaled >> 32);
        cb_q[j] <= ca_q[j];
        tc_q[j] <= 31'(q);
        cc_q[j] <= {cb_q[j][CW-1:R_LSB], s_new};
      end
    end
  end

  // Scale back by 2^-n with round half up.
  logic [CW-1:0] ctx_f;
  logic [32:0]   s_f;
  logic [5:0]    sh_f;
  logic [33:0]   rnd_f;
  logic          vf_q;
  logic [16:0]   e_q;
  logic [SIDE_W-1:0] sdf_q;

  assign ctx_f = cc_q[EXP_TERMS-1];
  assign s_f   = ctx_f[32] ? 33'd0 : ctx_f[S_LSB +: 33];
  assign sh_f  = 6'(ctx_f[N_LSB +: 5]) + 6'(Q30_SHIFT);
  assign rnd_f = 34'(s_f) + (34'd1 << (sh_f - 6'd1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (en_i) begin
      vf_q <= vc_q[EXP_TERMS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q   <= 17'(rnd_f >> sh_f);
      sdf_q <= ctx_f[SD_LSB +: SIDE_W];
    end
  end

  assign vld_o  = vf_q;
  assign e_o    = e_q;
  assign side_o = sdf_q;

endmodule
`default_nettype wire

FILE: design/gbs_obuf.sv
// Two-entry output buffer that decouples the result side from the pipeline.
`timescale 1ns / 1ps
`default_nettype none
module gbs_obuf #(
  parameter int unsigned W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [W-1:0]      data_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_q, rd_q;
  logic [1:0]   cnt_q;
  logic         pop;

  assign pop         = (cnt_q != 2'd0) && !out_stall_i;
  assign ready_o     = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign data_o      = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire
